[rtl/wlfm_pkg.sv]
package wlfm_pkg;

    localparam int CFG_W = 20;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MONITORING_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REQUIRED_PAUSE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ABNORMAL_FLOW     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_ACTIVITY      = 2'd3;

    localparam logic [CFG_W-1:0] RST_MONITORING_PERIOD = CFG_W'(24 * 60 * 60);
    localparam logic [CFG_W-1:0] RST_REQUIRED_PAUSE    = CFG_W'(2 * 60 * 60);
    localparam logic [CFG_W-1:0] RST_ABNORMAL_FLOW     = CFG_W'(2 * 60 * 60);
    localparam logic [CFG_W-1:0] RST_MIN_ACTIVITY      = CFG_W'(1 * 60);

    typedef struct packed {
        logic pause_registered;
        logic window_expired;
        logic pause_active;
        logic flow_active;
        logic leak;
        logic abnormal;
        logic blink_phase;
    } t_flags;

endpackage

[rtl/wlfm_in_if.sv]
interface wlfm_in_if;
    logic valid;
    logic ready;
    logic pulse_level;
    logic button_press;
    logic second_tick;
    logic blink_tick;

    modport source (output valid, output pulse_level, output button_press,
                    output second_tick, output blink_tick, input ready);
    modport sink (input valid, input pulse_level, input button_press,
                  input second_tick, input blink_tick, output ready);
endinterface

[rtl/wlfm_out_if.sv]
interface wlfm_out_if;
    logic valid;
    logic ready;
    logic pulse_led;
    logic alarm_led;
    logic leak_alarm;
    logic abnormal_alarm;
    logic heartbeat_led;

    modport source (output valid, output pulse_led, output alarm_led,
                    output leak_alarm, output abnormal_alarm, output heartbeat_led,
                    input ready);
    modport sink (input valid, input pulse_led, input alarm_led,
                  input leak_alarm, input abnormal_alarm, input heartbeat_led,
                  output ready);
endinterface

[rtl/water_leak_flow_monitor.sv]
// water leak and flow monitor
// i_in carries one sample per request: flow-meter pulse level, reset button,
// one-second tick and blink tick. o_out returns exactly one result per
// sample: pulse led, alarm led, leak and abnormal alarms, heartbeat led.
// i_cfg_we / i_cfg_idx / i_cfg_data write the four timing registers
// (window, required pause, abnormal flow, minimum activity, in seconds);
// write only while no sample is in flight.
// a sample accepted at one clock edge updates the time, flow, pause and alarm
// state at that edge and its result is valid on o_out from the next cycle,
// through the single result register stage; one sample per cycle is taken
// while o_out takes each result.
// when o_out stalls the result register holds and i_in.ready stays high
// only if that result is taken in the same cycle; a new sample is taken as
// soon as the result register frees up.
// synchronous reset clears time counters, flags and result valid and loads
// the timing registers with 86400, 7200, 7200 and 60 seconds.
module water_leak_flow_monitor
    import wlfm_pkg::*;
#(
    parameter int TIME_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    wlfm_in_if.sink              i_in,
    wlfm_out_if.source           o_out
);

    localparam int TW = TIME_WIDTH;
    localparam int CMP_W = (TW > CFG_W) ? TW : CFG_W;
    localparam logic [TW-1:0] TMAX = '1;

    logic [CFG_W-1:0] r_period, r_req_pause, r_abn_flow, r_min_act;

    logic [TW-1:0] r_now, r_win_start, r_last_pulse, r_pause_s, r_flow_s;
    t_flags        r_fl;

    logic [TW-1:0] n_now, n_win_start, n_last_pulse, n_pause_s, n_flow_s;
    t_flags        n_fl;
    logic          n_alarm_led;

    logic r_out_valid;
    logic r_pulse_led, r_alarm_led, r_leak, r_abn, r_heart;

    logic accept;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        logic [TW-1:0] fs1, ps1, since_pulse, since_win;
        logic          timeout, close;
        n_fl = r_fl;
        fs1 = (i_in.second_tick && r_fl.flow_active)
            ? ((r_flow_s == TMAX) ? TMAX : r_flow_s + TW'(1)) : r_flow_s;
        ps1 = (i_in.second_tick && r_fl.pause_active)
            ? ((r_pause_s == TMAX) ? TMAX : r_pause_s + TW'(1)) : r_pause_s;
        n_now = i_in.second_tick ? r_now + TW'(1) : r_now;
        n_win_start = r_win_start;
        n_flow_s = fs1;
        n_pause_s = ps1;
        if (i_in.button_press) begin
            n_win_start = n_now;
            n_fl.window_expired = 1'b0;
            n_pause_s = '0;
            n_fl.flow_active = 1'b0;
            n_flow_s = '0;
            n_fl.abnormal = 1'b0;
            n_fl.leak = 1'b0;
        end
        n_last_pulse = r_last_pulse;
        if (i_in.pulse_level) begin
            n_last_pulse = n_now;
            n_fl.flow_active = 1'b1;
            n_fl.pause_active = 1'b0;
            n_pause_s = '0;
        end else begin
            n_fl.pause_active = 1'b1;
        end
        since_pulse = n_now - n_last_pulse;
        timeout = CMP_W'(since_pulse) >= CMP_W'(r_min_act);
        if (timeout) begin
            n_fl.flow_active = 1'b0;
            n_flow_s = '0;
        end
        if (CMP_W'(n_pause_s) >= CMP_W'(r_req_pause)) begin
            n_fl.pause_registered = 1'b1;
        end
        since_win = n_now - n_win_start;
        if (CMP_W'(since_win) >= CMP_W'(r_period)) begin
            n_fl.window_expired = 1'b1;
        end
        close = n_fl.window_expired && i_in.pulse_level;
        if (close) begin
            if (!n_fl.pause_registered) begin
                n_fl.leak = 1'b1;
            end
            n_fl.pause_registered = 1'b0;
            n_fl.window_expired = 1'b0;
            n_win_start = n_now;
        end
        if (CMP_W'(n_flow_s) >= CMP_W'(r_abn_flow)) begin
            n_fl.abnormal = 1'b1;
        end
        n_alarm_led = n_fl.abnormal ? r_fl.blink_phase : n_fl.leak;
        n_fl.blink_phase = r_fl.blink_phase ^ i_in.blink_tick;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period     <= RST_MONITORING_PERIOD;
            r_req_pause  <= RST_REQUIRED_PAUSE;
            r_abn_flow   <= RST_ABNORMAL_FLOW;
            r_min_act    <= RST_MIN_ACTIVITY;
            r_now        <= '0;
            r_win_start  <= '0;
            r_last_pulse <= '0;
            r_pause_s    <= '0;
            r_flow_s     <= '0;
            r_fl         <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MONITORING_PERIOD: r_period    <= i_cfg_data;
                    REG_REQUIRED_PAUSE:    r_req_pause <= i_cfg_data;
                    REG_ABNORMAL_FLOW:     r_abn_flow  <= i_cfg_data;
                    REG_MIN_ACTIVITY:      r_min_act   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_now        <= n_now;
                r_win_start  <= n_win_start;
                r_last_pulse <= n_last_pulse;
                r_pause_s    <= n_pause_s;
                r_flow_s     <= n_flow_s;
                r_fl         <= n_fl;
                r_out_valid  <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pulse_led <= i_in.pulse_level;
            r_alarm_led <= n_alarm_led;
            r_leak      <= n_fl.leak;
            r_abn       <= n_fl.abnormal;
            r_heart     <= n_fl.blink_phase;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.pulse_led      = r_pulse_led;
    assign o_out.alarm_led      = r_alarm_led;
    assign o_out.leak_alarm     = r_leak;
    assign o_out.abnormal_alarm = r_abn;
    assign o_out.heartbeat_led  = r_heart;

`ifndef ASSERT_OFF
    a_led_shows_leak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.abnormal_alarm |-> o_out.alarm_led == o_out.leak_alarm)
        else $error("alarm led disagrees with leak alarm");

    a_idle_flow_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_fl.flow_active |-> r_flow_s == '0)
        else $error("flow time counting while flow inactive");

    a_button_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.button_press |=> r_flow_s == '0)
        else $error("button did not clear flow time");

    a_pulse_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.pulse_level |=> r_last_pulse == r_now && r_pause_s == '0)
        else $error("pulse not recorded");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("result valid right after reset");
`endif

endmodule

[sim/wlfm_alarm_checker.sv]
`timescale 1ns / 1ps

module wlfm_alarm_checker
    import wlfm_pkg::*;
#(
    parameter int TIME_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    wlfm_in_if                   i_in,
    wlfm_out_if                  i_out,
    output int                   o_pending,
    output int                   o_errors
);

    localparam int CMP_W = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;

    typedef logic [TIME_WIDTH-1:0] t_time;

    typedef struct packed {
        logic pulse_led;
        logic alarm_led;
        logic leak_alarm;
        logic abnormal_alarm;
        logic heartbeat_led;
    } t_leds;

    logic [CFG_W-1:0] window_len;
    logic [CFG_W-1:0] pause_need;
    logic [CFG_W-1:0] abnormal_len;
    logic [CFG_W-1:0] idle_limit;

    t_time  now_s;
    t_time  window_start;
    t_time  last_pulse;
    t_time  pause_s;
    t_time  flow_s;
    t_flags flags;

    t_leds expected_leds[$];

    function automatic t_time since(t_time t);
        return now_s - t;
    endfunction

    function automatic t_time sat_inc(t_time v);
        return (v == '1) ? v : v + t_time'(1);
    endfunction

    function automatic t_leds next_leds(logic pulse, logic button, logic sec, logic blink);
        t_leds r;
        if (sec) begin
            if (flags.flow_active) flow_s = sat_inc(flow_s);
            if (flags.pause_active) pause_s = sat_inc(pause_s);
            now_s = now_s + t_time'(1);
        end
        if (button) begin
            window_start         = now_s;
            flags.window_expired = 1'b0;
            pause_s              = '0;
            flags.flow_active    = 1'b0;
            flow_s               = '0;
            flags.abnormal       = 1'b0;
            flags.leak           = 1'b0;
        end
        if (pulse) begin
            last_pulse         = now_s;
            flags.flow_active  = 1'b1;
            flags.pause_active = 1'b0;
            pause_s            = '0;
        end else begin
            flags.pause_active = 1'b1;
        end
        // flow stops after a quiet stretch
        if (CMP_W'(since(last_pulse)) >= CMP_W'(idle_limit)) begin
            flags.flow_active = 1'b0;
            flow_s            = '0;
        end
        if (CMP_W'(pause_s) >= CMP_W'(pause_need)) flags.pause_registered = 1'b1;
        if (CMP_W'(since(window_start)) >= CMP_W'(window_len)) flags.window_expired = 1'b1;
        // expired window closes on the next pulse
        if (flags.window_expired && pulse) begin
            if (!flags.pause_registered) flags.leak = 1'b1;
            flags.pause_registered = 1'b0;
            flags.window_expired   = 1'b0;
            window_start           = now_s;
        end
        if (CMP_W'(flow_s) >= CMP_W'(abnormal_len)) flags.abnormal = 1'b1;
        r.pulse_led      = pulse;
        r.alarm_led      = flags.abnormal ? flags.blink_phase : flags.leak;
        r.leak_alarm     = flags.leak;
        r.abnormal_alarm = flags.abnormal;
        if (blink) flags.blink_phase = ~flags.blink_phase;
        r.heartbeat_led  = flags.blink_phase;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_leds got;
        t_leds want;
        if (!i_rst_n) begin
            window_len   = RST_MONITORING_PERIOD;
            pause_need   = RST_REQUIRED_PAUSE;
            abnormal_len = RST_ABNORMAL_FLOW;
            idle_limit   = RST_MIN_ACTIVITY;
            now_s        = '0;
            window_start = '0;
            last_pulse   = '0;
            pause_s      = '0;
            flow_s       = '0;
            flags        = '0;
            expected_leds.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                got = {i_out.pulse_led, i_out.alarm_led, i_out.leak_alarm,
                       i_out.abnormal_alarm, i_out.heartbeat_led};
                if (expected_leds.size() == 0) begin
                    o_errors = o_errors + 1;
                    if (o_errors <= 10)
                        $display("unexpected result pulse/alarm/leak/abnormal/heartbeat %b",
                                 got);
                end else begin
                    want = expected_leds.pop_front();
                    if (got !== want) begin
                        o_errors = o_errors + 1;
                        if (o_errors <= 10)
                            $display("mismatch pulse/alarm/leak/abnormal/heartbeat: %s %b %s %b",
                                     "expected", want, "actual", got);
                    end
                end
            end
            if (i_in.valid && i_in.ready)
                expected_leds.push_back(next_leds(i_in.pulse_level, i_in.button_press,
                                                  i_in.second_tick, i_in.blink_tick));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MONITORING_PERIOD: window_len   = i_cfg_data;
                    REG_REQUIRED_PAUSE:    pause_need   = i_cfg_data;
                    REG_ABNORMAL_FLOW:     abnormal_len = i_cfg_data;
                    REG_MIN_ACTIVITY:      idle_limit   = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending <= expected_leds.size();
    end

endmodule

[sim/water_leak_flow_monitor_tb.sv]
`timescale 1ns / 1ps

module water_leak_flow_monitor_tb;
    import wlfm_pkg::*;

    localparam int TW = 18;
    localparam int N_DIRECTED = 23;

    // {pulse, button, second tick, blink tick}, sent from the top entry down
    localparam logic [N_DIRECTED-1:0][3:0] DIRECTED = {
        4'b1010, 4'b1011, 4'b1010, 4'b1010, 4'b1011, 4'b1001, 4'b1100, 4'b0010,
        4'b0011, 4'b0010, 4'b0010, 4'b0100, 4'b1010, 4'b0010, 4'b0000, 4'b0001,
        4'b0010, 4'b0010, 4'b1010, 4'b1111, 4'b0110, 4'b1010, 4'b0000
    };

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    int pending;
    int errors;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_len       = 0;
    int hold_id        = 0;
    int hold_seen      = 0;
    int hold_left      = 0;

    wlfm_in_if  samples ();
    wlfm_out_if leds ();

    water_leak_flow_monitor #(
        .TIME_WIDTH(TW)
    ) i_dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_in      (samples),
        .o_out     (leds)
    );

    wlfm_alarm_checker #(
        .TIME_WIDTH(TW)
    ) i_checker (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_in      (samples),
        .i_out     (leds),
        .o_pending (pending),
        .o_errors  (errors)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // result side, with an occasional long hold-off
    always @(negedge clk) begin
        if (hold_id != hold_seen) begin
            hold_seen = hold_id;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            leds.ready <= 1'b0;
        end else begin
            leds.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        #30_000_000;
        $display("FAIL water_leak_flow_monitor");
        $finish;
    end

    task automatic send_sample(input logic [3:0] s);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            samples.valid <= 1'b0;
            @(negedge clk);
        end
        samples.valid        <= 1'b1;
        samples.pulse_level  <= s[3];
        samples.button_press <= s[2];
        samples.second_tick  <= s[1];
        samples.blink_tick   <= s[0];
        do @(posedge clk); while (samples.ready !== 1'b1);
    endtask

    task automatic settle();
        @(negedge clk);
        samples.valid <= 1'b0;
        wait (pending == 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic load_config(input logic [CFG_W-1:0] period, input logic [CFG_W-1:0] pause,
                               input logic [CFG_W-1:0] abnormal, input logic [CFG_W-1:0] idle);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_MONITORING_PERIOD;
        cfg_data <= period;
        @(negedge clk);
        cfg_idx  <= REG_REQUIRED_PAUSE;
        cfg_data <= pause;
        @(negedge clk);
        cfg_idx  <= REG_ABNORMAL_FLOW;
        cfg_data <= abnormal;
        @(negedge clk);
        cfg_idx  <= REG_MIN_ACTIVITY;
        cfg_data <= idle;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic load_small_config();
        load_config(CFG_W'($urandom_range(30, 1)), CFG_W'($urandom_range(12, 1)),
                    CFG_W'($urandom_range(15, 1)), CFG_W'($urandom_range(8, 1)));
    endtask

    // runs of flow and silence with some noise
    task automatic flow_phase(input int n, input int idle_pct, input int stall_pct,
                              input bit pressure);
        logic       level;
        int         run_left;
        logic [3:0] s;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        level          = 1'b0;
        run_left       = 0;
        for (int i = 0; i < n; i++) begin
            if (run_left == 0) begin
                level    = ~level;
                run_left = $urandom_range(12, 1);
            end
            run_left = run_left - 1;
            s[3] = ($urandom_range(9) == 0) ? ~level : level;
            s[2] = ($urandom_range(31) == 0);
            s[1] = ($urandom_range(3) != 0);
            s[0] = ($urandom_range(3) == 0);
            if (pressure && i == n / 4) begin
                hold_len = 40;
                hold_id  = hold_id + 1;
            end
            if (pressure && i == n / 2) begin
                @(negedge clk);
                samples.valid <= 1'b0;
                wait (pending == 0);
            end
            send_sample(s);
        end
        settle();
    endtask

    initial begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_idx              = REG_MONITORING_PERIOD;
        cfg_data             = '0;
        samples.valid        = 1'b0;
        samples.pulse_level  = 1'b0;
        samples.button_press = 1'b0;
        samples.second_tick  = 1'b0;
        samples.blink_tick   = 1'b0;
        leds.ready           = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // short windows so every path shows up in a few requests
        load_config(3, 2, 4, 2);
        for (int i = N_DIRECTED - 1; i >= 0; i--)
            send_sample(DIRECTED[i]);
        settle();

        load_small_config();
        flow_phase(80, 0, 0, 1'b0);
        load_small_config();
        flow_phase(60, 66, 0, 1'b0);
        load_config('0, '0, '0, '0);
        flow_phase(50, 0, 66, 1'b0);
        load_config(1, 1, 1, 1);
        flow_phase(50, 7, 7, 1'b0);
        load_small_config();
        flow_phase(80, 0, 0, 1'b1);
        load_small_config();
        flow_phase(60, 0, 66, 1'b0);
        load_config(RST_MONITORING_PERIOD, RST_REQUIRED_PAUSE, RST_ABNORMAL_FLOW,
                    RST_MIN_ACTIVITY);
        flow_phase(30, 66, 0, 1'b0);

        repeat (4) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("PASS water_leak_flow_monitor");
        end else begin
            $display("FAIL water_leak_flow_monitor");
        end
        $finish;
    end

endmodule

[water_leak_flow_monitor.f]
rtl/wlfm_pkg.sv
rtl/wlfm_in_if.sv
rtl/wlfm_out_if.sv
rtl/water_leak_flow_monitor.sv
sim/wlfm_alarm_checker.sv
sim/water_leak_flow_monitor_tb.sv
